FILE: rtl/waypoint_steering_p_controller_defines.svh
// assertion helpers for the waypoint steering block
// all checks are clocked on i_clk and masked while i_rst_n is low
`ifndef WAYPOINT_STEERING_P_CONTROLLER_DEFINES_SVH
`define WAYPOINT_STEERING_P_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define WPSC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// fixed-delay implication
`define WPSC_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

FILE: rtl/wpsc_pkg.sv
`timescale 1ns / 1ps
package wpsc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int COORD_WIDTH_DEF   = 16;

    // angle accumulator, radians with 24 fraction bits
    localparam int ZW = 28;
    localparam logic signed [ZW-1:0] ANG_PI_Q24 = 28'sd52707179;
    // 1/K of the cordic gain, 16 fraction bits
    localparam logic [15:0] INV_K_Q16 = 16'd39797;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] BEARING_GAIN_RST  = 16'd27853;
    localparam logic [15:0] DISTANCE_GAIN_RST = 16'd31130;
    localparam logic [14:0] NEAR_THRESH_RST   = 15'd410;
    localparam logic [15:0] REV_SCALE_RST     = 16'd10923;
    localparam logic [15:0] ALIGN_SCALE_RST   = 16'd16384;

    typedef enum logic [1:0] {
        MODE_ALIGN   = 2'd0,
        MODE_REVERSE = 2'd1,
        MODE_FORWARD = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEARING_GAIN  = 3'd0,
        CFG_DISTANCE_GAIN = 3'd1,
        CFG_NEAR_THRESH   = 3'd2,
        CFG_REV_SCALE     = 3'd3,
        CFG_ALIGN_SCALE   = 3'd4
    } t_cfg_index;

    // per-word info that rides alongside the cordic stages
    typedef struct packed {
        t_mode              mode;
        logic               zero;
        logic signed [15:0] heading;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/waypoint_steering_p_controller.sv
// o_done rises when a word taken with start has passed the entry register, which loads on the edge
// that takes start, then the cordic stages and then the five post stages that follow them
// throughput: one word per clock, set by the fully unrolled cordic and post pipeline
// busy never rises; results cannot be held off and leave after the fixed latency
// reset (synchronous, i_rst_n low) clears all valid bits and loads the default gains
`timescale 1ns / 1ps
`include "waypoint_steering_p_controller_defines.svh"
module waypoint_steering_p_controller #(
    parameter int CORDIC_STAGES = wpsc_pkg::CORDIC_STAGES_DEF,
    parameter int COORD_WIDTH   = wpsc_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [15:0]                 i_offset_x,
    input  logic signed [15:0]                 i_offset_y,
    input  logic signed [15:0]                 i_heading_error,
    input  logic                               i_cfg_we,
    input  logic [wpsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wpsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_done,
    output logic signed [15:0]                 o_turn_rate,
    output logic signed [15:0]                 o_forward_speed,
    output logic [1:0]                         o_drive_mode
);

    localparam int XW    = COORD_WIDTH + 6;
    localparam int ZW    = wpsc_pkg::ZW;
    localparam int HIW   = COORD_WIDTH - 11;
    localparam int PSW   = COORD_WIDTH + 22;
    localparam int DSH   = COORD_WIDTH + 4;
    localparam int LAT   = CORDIC_STAGES + 6;

    // configuration registers
    logic [15:0] r_bgain, r_dgain, r_rscale, r_ascale;
    logic [14:0] r_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bgain  <= wpsc_pkg::BEARING_GAIN_RST;
            r_dgain  <= wpsc_pkg::DISTANCE_GAIN_RST;
            r_near   <= wpsc_pkg::NEAR_THRESH_RST;
            r_rscale <= wpsc_pkg::REV_SCALE_RST;
            r_ascale <= wpsc_pkg::ALIGN_SCALE_RST;
        end else if (i_cfg_we) begin
            case (wpsc_pkg::t_cfg_index'(i_cfg_index))
                wpsc_pkg::CFG_BEARING_GAIN:  r_bgain  <= i_cfg_data;
                wpsc_pkg::CFG_DISTANCE_GAIN: r_dgain  <= i_cfg_data;
                wpsc_pkg::CFG_NEAR_THRESH:   r_near   <= i_cfg_data[14:0];
                wpsc_pkg::CFG_REV_SCALE:     r_rscale <= i_cfg_data;
                wpsc_pkg::CFG_ALIGN_SCALE:   r_ascale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // mode decision at entry
    logic [16:0]     ax, ay;
    wpsc_pkg::t_side in_side;

    always_comb begin
        ax = i_offset_x[15] ? 17'(-(17'(i_offset_x))) : 17'(i_offset_x);
        ay = i_offset_y[15] ? 17'(-(17'(i_offset_y))) : 17'(i_offset_y);
        in_side.heading = i_heading_error;
        in_side.zero    = (i_offset_x == '0) && (i_offset_y == '0);
        if ((ax < {2'b00, r_near}) && (ay < {2'b00, r_near})) begin
            in_side.mode = wpsc_pkg::MODE_ALIGN;
        end else if (i_offset_x[15]) begin
            in_side.mode = wpsc_pkg::MODE_REVERSE;
        end else begin
            in_side.mode = wpsc_pkg::MODE_FORWARD;
        end
    end

    logic                  c_valid;
    logic signed [XW-1:0]  c_cx;
    logic signed [ZW-1:0]  c_z;
    wpsc_pkg::t_side       c_side;

    wpsc_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_x     (i_offset_x),
        .i_y     (i_offset_y),
        .i_side  (in_side),
        .o_valid (c_valid),
        .o_cx    (c_cx),
        .o_z     (c_z),
        .o_side  (c_side)
    );

    // post stage 1: round bearing, split 1/K product, heading product
    logic signed [ZW:0]      z_rnd;
    logic signed [16:0]      n_p1_bearing;
    logic [31:0]             n_p1_plo;
    logic [HIW+15:0]         n_p1_phi;
    logic signed [32:0]      n_p1_hprod;

    logic                    r_p1_valid;
    logic signed [16:0]      r_p1_bearing;
    logic [31:0]             r_p1_plo;
    logic [HIW+15:0]         r_p1_phi;
    logic signed [32:0]      r_p1_hprod;
    wpsc_pkg::t_mode         r_p1_mode;

    always_comb begin
        z_rnd      = (ZW+1)'(c_z) + (c_z[ZW-1] ? (ZW+1)'(1023) : (ZW+1)'(1024));
        n_p1_hprod = c_side.heading * $signed({1'b0, r_ascale});
        // a zero vector has no defined angle
        if (c_side.zero) begin
            n_p1_bearing = '0;
            n_p1_plo     = '0;
            n_p1_phi     = '0;
        end else begin
            n_p1_bearing = z_rnd[ZW-1:11];
            n_p1_plo     = c_cx[15:0] * wpsc_pkg::INV_K_Q16;
            n_p1_phi     = c_cx[XW-2:16] * wpsc_pkg::INV_K_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_bearing <= n_p1_bearing;
        r_p1_plo     <= n_p1_plo;
        r_p1_phi     <= n_p1_phi;
        r_p1_hprod   <= n_p1_hprod;
        r_p1_mode    <= c_side.mode;
    end

    // post stage 2: distance, bearing gain product, align turn
    logic [PSW-1:0]          dsum;
    logic signed [33:0]      hr;
    logic [17:0]             n_p2_dist;
    logic signed [33:0]      n_p2_bprod;

    logic                    r_p2_valid;
    logic [17:0]             r_p2_dist;
    logic signed [33:0]      r_p2_bprod;
    logic signed [18:0]      r_p2_nturn;
    wpsc_pkg::t_mode         r_p2_mode;

    always_comb begin
        dsum       = PSW'({r_p1_phi, 16'h0000}) + PSW'(r_p1_plo) + (PSW'(1) << (DSH - 1));
        n_p2_dist  = dsum[PSW-1:DSH];
        n_p2_bprod = r_p1_bearing * $signed({1'b0, r_bgain});
        hr         = 34'(r_p1_hprod) + (r_p1_hprod[32] ? 34'(16383) : 34'(16384));
    end

    always_ff @(posedge i_clk) begin
        r_p2_dist  <= n_p2_dist;
        r_p2_bprod <= n_p2_bprod;
        r_p2_nturn <= hr[33:15];
        r_p2_mode  <= r_p1_mode;
    end

    // post stage 3: bearing term, distance gain product
    logic signed [34:0]      br;
    logic [33:0]             n_p3_dprod;

    logic                    r_p3_valid;
    logic signed [17:0]      r_p3_bterm;
    logic [33:0]             r_p3_dprod;
    logic signed [18:0]      r_p3_nturn;
    wpsc_pkg::t_mode         r_p3_mode;

    always_comb begin
        br         = 35'(r_p2_bprod) + (r_p2_bprod[33] ? 35'(16383) : 35'(16384));
        n_p3_dprod = r_p2_dist * r_dgain;
    end

    always_ff @(posedge i_clk) begin
        r_p3_bterm <= br[32:15];
        r_p3_dprod <= n_p3_dprod;
        r_p3_nturn <= r_p2_nturn;
        r_p3_mode  <= r_p2_mode;
    end

    // post stage 4: distance term, reverse turn product
    logic [34:0]             dr;
    logic signed [34:0]      n_p4_rprod;

    logic                    r_p4_valid;
    logic [17:0]             r_p4_dterm;
    logic signed [34:0]      r_p4_rprod;
    logic signed [17:0]      r_p4_bterm;
    logic signed [18:0]      r_p4_nturn;
    wpsc_pkg::t_mode         r_p4_mode;

    always_comb begin
        dr         = 35'(r_p3_dprod) + 35'(16384);
        n_p4_rprod = r_p3_bterm * $signed({1'b0, r_rscale});
    end

    always_ff @(posedge i_clk) begin
        r_p4_dterm <= dr[32:15];
        r_p4_rprod <= n_p4_rprod;
        r_p4_bterm <= r_p3_bterm;
        r_p4_nturn <= r_p3_nturn;
        r_p4_mode  <= r_p3_mode;
    end

    // post stage 5: mode select and saturation
    logic signed [35:0]      rr;
    logic signed [23:0]      dterm_ext;
    logic signed [15:0]      n_turn, n_speed;

    logic                    r_done;
    logic signed [15:0]      r_turn, r_speed;
    logic [1:0]              r_mode;

    always_comb begin
        rr        = 36'(r_p4_rprod) + (r_p4_rprod[34] ? 36'(16383) : 36'(16384));
        dterm_ext = $signed(24'(r_p4_dterm));
        case (r_p4_mode)
            wpsc_pkg::MODE_ALIGN: begin
                n_turn  = wpsc_pkg::sat16(24'(r_p4_nturn));
                n_speed = '0;
            end
            wpsc_pkg::MODE_REVERSE: begin
                n_turn  = wpsc_pkg::sat16(-(24'($signed(rr[35:15]))));
                n_speed = wpsc_pkg::sat16(-dterm_ext);
            end
            wpsc_pkg::MODE_FORWARD: begin
                n_turn  = wpsc_pkg::sat16(24'(r_p4_bterm));
                n_speed = wpsc_pkg::sat16(dterm_ext);
            end
            default: begin
                n_turn  = '0;
                n_speed = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_turn  <= n_turn;
        r_speed <= n_speed;
        r_mode  <= r_p4_mode;
    end

    // valid chain through the post stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_p1_valid <= c_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
            r_done     <= r_p4_valid;
        end
    end

    assign o_done          = r_done;
    assign o_turn_rate     = r_turn;
    assign o_forward_speed = r_speed;
    assign o_drive_mode    = r_mode;

    `WPSC_ASSERT_DELAY(a_fixed_latency, start && !busy, LAT, o_done, "word lost in pipeline")
    `WPSC_ASSERT_IMPLIES(a_align_stops,
        o_done && (o_drive_mode == wpsc_pkg::MODE_ALIGN),
        o_forward_speed == '0, "align word moves")
    `WPSC_ASSERT_IMPLIES(a_reverse_back,
        o_done && (o_drive_mode == wpsc_pkg::MODE_REVERSE),
        o_forward_speed[15] || (o_forward_speed == '0), "reverse word drives forward")
    `WPSC_ASSERT_IMPLIES(a_forward_fwd,
        o_done && (o_drive_mode == wpsc_pkg::MODE_FORWARD),
        !o_forward_speed[15], "forward word drives backward")

endmodule

FILE: rtl/wpsc_cordic.sv
`timescale 1ns / 1ps
module wpsc_cordic #(
    parameter int CORDIC_STAGES = wpsc_pkg::CORDIC_STAGES_DEF,
    parameter int COORD_WIDTH   = wpsc_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [15:0]                i_x,
    input  logic signed [15:0]                i_y,
    input  wpsc_pkg::t_side                   i_side,
    output logic                              o_valid,
    output logic signed [COORD_WIDTH+5:0]     o_cx,
    output logic signed [wpsc_pkg::ZW-1:0]    o_z,
    output wpsc_pkg::t_side                   o_side
);

    localparam int XW    = COORD_WIDTH + 6;
    localparam int GUARD = COORD_WIDTH - 12;
    localparam int ZW    = wpsc_pkg::ZW;

    logic signed [XW-1:0]  r_cx [0:CORDIC_STAGES];
    logic signed [XW-1:0]  r_cy [0:CORDIC_STAGES];
    logic signed [ZW-1:0]  r_z  [0:CORDIC_STAGES];
    wpsc_pkg::t_side       r_side [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0] r_valid;

    logic signed [XW-1:0] n_cx0, n_cy0, x_sc, y_sc;
    logic signed [ZW-1:0] n_z0;

    // left half plane is folded over, accumulator starts at +/- pi
    always_comb begin
        x_sc = XW'(i_x) <<< GUARD;
        y_sc = XW'(i_y) <<< GUARD;
        if (i_x[15]) begin
            n_cx0 = -x_sc;
            n_cy0 = -y_sc;
            n_z0  = i_y[15] ? -wpsc_pkg::ANG_PI_Q24 : wpsc_pkg::ANG_PI_Q24;
        end else begin
            n_cx0 = x_sc;
            n_cy0 = y_sc;
            n_z0  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[CORDIC_STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0]   <= n_cx0;
        r_cy[0]   <= n_cy0;
        r_z[0]    <= n_z0;
        r_side[0] <= i_side;
    end

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        logic signed [XW-1:0] dx, dy;
        logic                 cy_pos;

        always_comb begin
            dx     = r_cy[s] >>> s;
            dy     = r_cx[s] >>> s;
            cy_pos = !r_cy[s][XW-1] && (r_cy[s] != '0);
        end

        always_ff @(posedge i_clk) begin
            if (cy_pos) begin
                r_cx[s+1] <= r_cx[s] + dx;
                r_cy[s+1] <= r_cy[s] - dy;
                r_z[s+1]  <= r_z[s] + wpsc_pkg::atan_q24(5'(s));
            end else begin
                r_cx[s+1] <= r_cx[s] - dx;
                r_cy[s+1] <= r_cy[s] + dy;
                r_z[s+1]  <= r_z[s] - wpsc_pkg::atan_q24(5'(s));
            end
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_valid[CORDIC_STAGES];
    assign o_cx    = r_cx[CORDIC_STAGES];
    assign o_z     = r_z[CORDIC_STAGES];
    assign o_side  = r_side[CORDIC_STAGES];

endmodule
